>>> design/sse3e_pkg.sv
package sse3e_pkg;

  localparam int unsigned MaxBytes   = 10;
  localparam int unsigned RmBytes    = 6;
  localparam int unsigned QueueDepth = 2;
  localparam logic [4:0]  CapReset   = 5'd16;

  localparam logic [3:0] OP_ADDSUBPD = 4'd0;
  localparam logic [3:0] OP_ADDSUBPS = 4'd1;
  localparam logic [3:0] OP_HADDPD   = 4'd2;
  localparam logic [3:0] OP_HADDPS   = 4'd3;
  localparam logic [3:0] OP_HSUBPD   = 4'd4;
  localparam logic [3:0] OP_HSUBPS   = 4'd5;
  localparam logic [3:0] OP_LDDQU    = 4'd6;
  localparam logic [3:0] OP_MOVDDUP  = 4'd7;
  localparam logic [3:0] OP_MOVSHDUP = 4'd8;
  localparam logic [3:0] OP_MOVSLDUP = 4'd9;
  localparam logic [3:0] OP_FISTTP   = 4'd10;
  localparam logic [3:0] OP_MONITOR  = 4'd11;
  localparam logic [3:0] OP_MWAIT    = 4'd12;

  localparam logic [1:0] KIND_REG = 2'd0;
  localparam logic [1:0] KIND_MEM = 2'd1;

  localparam logic [2:0] AM_BASE       = 3'd0;
  localparam logic [2:0] AM_BASE_INDEX = 3'd1;
  localparam logic [2:0] AM_INDEX      = 3'd2;
  localparam logic [2:0] AM_RIP        = 3'd3;
  localparam logic [2:0] AM_ABS        = 3'd4;

  localparam logic [1:0] SW_16 = 2'd0;
  localparam logic [1:0] SW_32 = 2'd1;
  localparam logic [1:0] SW_BAD = 2'd3;

  localparam logic [7:0] BYTE_REX     = 8'h40;
  localparam logic [7:0] BYTE_MODRM_R = 8'hc0;
  localparam logic [7:0] BYTE_SIB_ABS = 8'h25;
  localparam logic [7:0] BYTE_ESC     = 8'h0f;
  localparam logic [7:0] BYTE_GRP7    = 8'h01;
  localparam logic [7:0] BYTE_MONITOR = 8'hc8;
  localparam logic [7:0] BYTE_MWAIT   = 8'hc9;
  localparam logic [7:0] BYTE_FIST16  = 8'hdf;
  localparam logic [7:0] BYTE_FIST32  = 8'hdb;
  localparam logic [7:0] BYTE_FIST64  = 8'hdd;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OPERAND  = 2'd1,
    ST_ADDRESS  = 2'd2,
    ST_CAPACITY = 2'd3
  } status_t;

  typedef struct packed {
    logic [3:0]         operation;
    logic [1:0]         operand_count;
    logic [1:0]         dst_kind;
    logic [1:0]         src_kind;
    logic [3:0]         modrm_reg_number;
    logic [3:0]         rm_or_base_reg;
    logic [2:0]         address_mode;
    logic [3:0]         index_reg;
    logic [3:0]         scale;
    logic               has_displacement;
    logic signed [31:0] displacement;
    logic [1:0]         store_width;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
    logic [1:0] status;
    logic [3:0] instruction_length;
  } out_item_t;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [3:0]               len;
    status_t                  status;
  } entry_t;

  function automatic logic [7:0] bin_prefix(input logic [3:0] op);
    logic [7:0] p;
    unique case (op)
      OP_ADDSUBPD, OP_HADDPD, OP_HSUBPD: p = 8'h66;
      OP_MOVSHDUP, OP_MOVSLDUP:          p = 8'hf3;
      default:                           p = 8'hf2;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] bin_opcode(input logic [3:0] op);
    logic [7:0] o;
    unique case (op)
      OP_ADDSUBPD, OP_ADDSUBPS: o = 8'hd0;
      OP_HADDPD, OP_HADDPS:     o = 8'h7c;
      OP_HSUBPD, OP_HSUBPS:     o = 8'h7d;
      OP_LDDQU:                 o = 8'hf0;
      OP_MOVSHDUP:              o = 8'h16;
      default:                  o = 8'h12;
    endcase
    return o;
  endfunction

endpackage

>>> design/sse3e_if.sv
interface sse3e_in_if;
  logic                 valid;
  logic                 ready;
  sse3e_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sse3e_out_if;
  logic                 valid;
  logic                 ready;
  sse3e_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sse3e_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/sse3_instruction_encoder.sv
// Each item is written into the queue, then its first byte is registered at the emitter output.
// Throughput: one result byte per cycle from the byte emitter while the receiver
// is ready; an item gives 2 to 10 bytes, or a single byte for an error result.
// Input is taken while the queue has room, so items follow back to back.
// Reset (rst_n low, synchronous): queue and output emptied, capacity set to 16.
module sse3_instruction_encoder #(
  parameter int unsigned QUEUE_DEPTH = sse3e_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  sse3e_in_if.sink    in_ch,
  sse3e_out_if.source out_ch,
  sse3e_cfg_if.sink   cfg_ch
);

  logic [4:0]        cap_r;
  sse3e_pkg::entry_t enc_entry;
  sse3e_pkg::entry_t q_head;
  logic              q_full, q_empty, q_pop, q_push;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !q_full;
  assign q_push       = in_ch.valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= sse3e_pkg::CapReset;
    end else if (cfg_ch.valid) begin
      cap_r <= cfg_ch.data;
    end
  end

  sse3e_front u_front (
    .item  (in_ch.data),
    .cap   (cap_r),
    .entry (enc_entry)
  );

  sse3e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (enc_entry),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  sse3e_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (q_head),
    .empty  (q_empty),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

endmodule

>>> design/sse3e_front.sv
module sse3e_front (
  input  sse3e_pkg::in_item_t item,
  input  logic [4:0]          cap,
  output sse3e_pkg::entry_t   entry
);

  always_comb begin
    sse3e_pkg::status_t          st;
    logic [3:0][7:0]             h;
    logic [2:0]                  hlen;
    logic [sse3e_pkg::RmBytes-1:0][7:0] rm;
    logic [2:0]                  rmlen;
    logic                        rex_r, rex_x, rex_b;
    logic                        use_rm;
    logic [1:0]                  kind;
    logic [2:0]                  reg3;
    logic [31:0]                 disp;
    logic                        scale_ok;
    logic [1:0]                  sb;
    logic [1:0]                  md;
    logic                        sib_needed;
    logic [2:0]                  ib;
    logic [3:0]                  len;
    logic [3:0]                  k;
    logic [7:0]                  rex_byte;
    logic [7:0]                  fist_op;

    st         = sse3e_pkg::ST_OK;
    h          = '0;
    hlen       = 3'd0;
    rm         = '0;
    rmlen      = 3'd0;
    rex_r      = 1'b0;
    rex_x      = 1'b0;
    rex_b      = 1'b0;
    use_rm     = 1'b0;
    kind       = sse3e_pkg::KIND_REG;
    reg3       = 3'd0;
    md         = 2'd0;
    sib_needed = 1'b0;
    ib         = 3'd4;
    disp       = item.has_displacement ? item.displacement : 32'd0;
    scale_ok   = (item.scale == 4'd0) || (item.scale == 4'd1) || (item.scale == 4'd2) ||
                 (item.scale == 4'd4) || (item.scale == 4'd8);
    sb         = (item.scale == 4'd8) ? 2'd3 : (item.scale == 4'd4) ? 2'd2 :
                 (item.scale == 4'd2) ? 2'd1 : 2'd0;

    priority if (item.operation <= sse3e_pkg::OP_MOVSLDUP) begin
      if (item.operand_count != 2'd2 || item.dst_kind != sse3e_pkg::KIND_REG) begin
        st = sse3e_pkg::ST_OPERAND;
      end else begin
        use_rm = 1'b1;
        kind   = item.src_kind;
        reg3   = item.modrm_reg_number[2:0];
        rex_r  = item.modrm_reg_number[3];
      end
    end else if (item.operation == sse3e_pkg::OP_FISTTP) begin
      if (item.operand_count != 2'd1 || item.dst_kind != sse3e_pkg::KIND_MEM ||
          item.store_width == sse3e_pkg::SW_BAD) begin
        st = sse3e_pkg::ST_OPERAND;
      end else begin
        use_rm = 1'b1;
        kind   = sse3e_pkg::KIND_MEM;
        reg3   = 3'd1;
      end
    end else if (item.operation == sse3e_pkg::OP_MONITOR ||
                 item.operation == sse3e_pkg::OP_MWAIT) begin
      if (item.operand_count != 2'd0) begin
        st = sse3e_pkg::ST_OPERAND;
      end else begin
        h[0] = sse3e_pkg::BYTE_ESC;
        h[1] = sse3e_pkg::BYTE_GRP7;
        h[2] = (item.operation == sse3e_pkg::OP_MONITOR) ? sse3e_pkg::BYTE_MONITOR :
                                                            sse3e_pkg::BYTE_MWAIT;
        hlen = 3'd3;
      end
    end else begin
      st = sse3e_pkg::ST_OPERAND;
    end

    if (use_rm) begin
      priority if (kind == sse3e_pkg::KIND_REG) begin
        rm[0] = sse3e_pkg::BYTE_MODRM_R | {2'b00, reg3, item.rm_or_base_reg[2:0]};
        rmlen = 3'd1;
        rex_b = item.rm_or_base_reg[3];
      end else if (kind != sse3e_pkg::KIND_MEM) begin
        st = sse3e_pkg::ST_OPERAND;
      end else if (!scale_ok) begin
        st = sse3e_pkg::ST_ADDRESS;
      end else begin
        unique case (item.address_mode)
          sse3e_pkg::AM_RIP: begin
            rm[0]   = {2'b00, reg3, 3'd5};
            rm[4:1] = disp;
            rmlen   = 3'd5;
          end
          sse3e_pkg::AM_ABS: begin
            rm[0]   = {2'b00, reg3, 3'd4};
            rm[1]   = sse3e_pkg::BYTE_SIB_ABS;
            rm[5:2] = disp;
            rmlen   = 3'd6;
          end
          sse3e_pkg::AM_INDEX: begin
            rex_x   = item.index_reg[3];
            rm[0]   = {2'b00, reg3, 3'd4};
            rm[1]   = {sb, item.index_reg[2:0], 3'd5};
            rm[5:2] = disp;
            rmlen   = 3'd6;
          end
          sse3e_pkg::AM_BASE, sse3e_pkg::AM_BASE_INDEX: begin
            priority if (!item.has_displacement && item.rm_or_base_reg[2:0] != 3'd5) begin
              md = 2'd0;
            end else if (item.has_displacement &&
                         (disp[31:7] == '0 || disp[31:7] == '1)) begin
              md = 2'd1;
            end else begin
              md = 2'd2;
            end
            rex_b = item.rm_or_base_reg[3];
            sib_needed = (item.address_mode == sse3e_pkg::AM_BASE_INDEX) ||
                         (item.rm_or_base_reg[2:0] == 3'd4);
            if (item.address_mode == sse3e_pkg::AM_BASE_INDEX) begin
              ib    = item.index_reg[2:0];
              rex_x = item.index_reg[3];
            end
            if (sib_needed) begin
              rm[0]   = {md, reg3, 3'd4};
              rm[1]   = {sb, ib, item.rm_or_base_reg[2:0]};
              rm[5:2] = disp;
            end else begin
              rm[0]   = {md, reg3, item.rm_or_base_reg[2:0]};
              rm[4:1] = disp;
            end
            rmlen = 3'd1 + {2'b00, sib_needed} +
                    ((md == 2'd1) ? 3'd1 : (md == 2'd2) ? 3'd4 : 3'd0);
          end
          default: st = sse3e_pkg::ST_ADDRESS;
        endcase
      end

      rex_byte = sse3e_pkg::BYTE_REX | {5'b00000, rex_r, rex_x, rex_b};
      fist_op  = (item.store_width == sse3e_pkg::SW_16) ? sse3e_pkg::BYTE_FIST16 :
                 (item.store_width == sse3e_pkg::SW_32) ? sse3e_pkg::BYTE_FIST32 :
                                                          sse3e_pkg::BYTE_FIST64;
      if (item.operation == sse3e_pkg::OP_FISTTP) begin
        if (rex_r || rex_x || rex_b) begin
          h[0] = rex_byte;
          h[1] = fist_op;
          hlen = 3'd2;
        end else begin
          h[0] = fist_op;
          hlen = 3'd1;
        end
      end else begin
        h[0] = sse3e_pkg::bin_prefix(item.operation);
        if (rex_r || rex_x || rex_b) begin
          h[1] = rex_byte;
          h[2] = sse3e_pkg::BYTE_ESC;
          h[3] = sse3e_pkg::bin_opcode(item.operation);
          hlen = 3'd4;
        end else begin
          h[1] = sse3e_pkg::BYTE_ESC;
          h[2] = sse3e_pkg::bin_opcode(item.operation);
          hlen = 3'd3;
        end
      end
    end else begin
      rex_byte = '0;
      fist_op  = '0;
    end

    len = {1'b0, hlen} + {1'b0, rmlen};
    if (st == sse3e_pkg::ST_OK && {1'b0, len} > cap) begin
      st = sse3e_pkg::ST_CAPACITY;
    end

    for (int i = 0; i < sse3e_pkg::MaxBytes; i++) begin
      k = 4'(i) - {1'b0, hlen};
      if (4'(i) < {1'b0, hlen}) begin
        entry.bytes[i] = h[2'(i)];
      end else if (k < 4'(sse3e_pkg::RmBytes)) begin
        entry.bytes[i] = rm[k[2:0]];
      end else begin
        entry.bytes[i] = '0;
      end
    end
    entry.len    = len;
    entry.status = st;
  end

endmodule

>>> design/sse3e_queue.sv
module sse3e_queue #(
  parameter int unsigned DEPTH = sse3e_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sse3e_pkg::entry_t push_data,
  output logic              full,
  input  logic              pop,
  output sse3e_pkg::entry_t head,
  output logic              empty
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  sse3e_pkg::entry_t slot_r [DEPTH];
  logic [PtrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]   count_r;

  assign full  = (count_r == CntW'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> design/sse3e_back.sv
module sse3e_back (
  input  logic              clk,
  input  logic              rst_n,
  input  sse3e_pkg::entry_t head,
  input  logic              empty,
  output logic              pop,
  sse3e_out_if.source       out_ch
);

  logic                 out_valid_r;
  sse3e_pkg::out_item_t out_data_r;
  logic [3:0]           idx_r;
  logic                 take, fire, is_err, last;

  assign take   = !out_valid_r || out_ch.ready;
  assign fire   = take && !empty;
  assign is_err = (head.status != sse3e_pkg::ST_OK);
  assign last   = is_err || (idx_r == head.len - 4'd1);
  assign pop    = fire && last;

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r.out_byte           <= is_err ? 8'd0 : head.bytes[idx_r];
      out_data_r.last_byte          <= last;
      out_data_r.status             <= head.status;
      out_data_r.instruction_length <= is_err ? 4'd0 : head.len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (take) begin
        out_valid_r <= !empty;
      end
      if (fire) begin
        idx_r <= last ? 4'd0 : idx_r + 4'd1;
      end
    end
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam logic [3:0] OP_RSVD13  = 4'd13;
  localparam logic [3:0] OP_RSVD15  = 4'd15;
  localparam logic [1:0] KIND_OTHER = 2'd2;
  localparam logic [2:0] AM_NONE    = 3'd5;
  localparam logic [1:0] SW_64      = 2'd2;

  localparam logic [1:0] MOD_NODISP = 2'd0;
  localparam logic [1:0] MOD_DISP8  = 2'd1;
  localparam logic [1:0] MOD_DISP32 = 2'd2;
  localparam logic [1:0] MOD_REG    = 2'd3;
  localparam logic [2:0] RM_SIB     = 3'd4;
  localparam logic [2:0] RM_DISP32  = 3'd5;
  localparam logic [2:0] NO_INDEX   = 3'd4;

  localparam logic [15:0] STALL_PATTERN = 16'b1000_1101_1001_0111;

  typedef struct {
    bit                  typed;
    sse3e_pkg::status_t  status;
    int unsigned         nbytes;
    logic [31:0]         bytes;
    sse3e_pkg::in_item_t item;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  sse3e_in_if  in_ch ();
  sse3e_out_if out_ch ();
  sse3e_cfg_if cfg_ch ();

  sse3_instruction_encoder u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  sse3e_pkg::out_item_t pending_bytes[$];
  logic [7:0]  enc_body[$];
  logic [2:0]  enc_rex;
  logic [4:0]  model_capacity = sse3e_pkg::CapReset;
  int unsigned mismatch_count = 0;
  int unsigned burst_left = 0;
  logic [7:0]  stall_phase = 8'd0;
  stim_row_t   directed[$];
  logic [4:0]  capacity_plan [7] = '{5'd0, 5'd31, 5'd3, 5'd10, 5'd4, 5'd16, 5'd0};

  function automatic void put_disp32(input logic [31:0] v);
    for (int i = 0; i < 4; i++) enc_body.push_back(v[8*i +: 8]);
  endfunction

  function automatic sse3e_pkg::status_t encode_operand(input sse3e_pkg::in_item_t it,
                                                        input logic [1:0] kind,
                                                        input logic [2:0] reg3);
    logic [31:0] disp;
    logic [1:0]  ss;
    logic [1:0]  md;
    logic [2:0]  ib;
    logic [2:0]  base3;
    disp  = it.has_displacement ? it.displacement : 32'd0;
    base3 = it.rm_or_base_reg[2:0];
    if (kind == sse3e_pkg::KIND_REG) begin
      enc_rex[0] = enc_rex[0] | it.rm_or_base_reg[3];
      enc_body.push_back({MOD_REG, reg3, base3});
      return sse3e_pkg::ST_OK;
    end
    if (kind != sse3e_pkg::KIND_MEM) return sse3e_pkg::ST_OPERAND;
    case (it.scale)
      4'd0, 4'd1: ss = 2'd0;
      4'd2:       ss = 2'd1;
      4'd4:       ss = 2'd2;
      4'd8:       ss = 2'd3;
      default:    return sse3e_pkg::ST_ADDRESS;
    endcase
    case (it.address_mode)
      sse3e_pkg::AM_RIP: begin
        enc_body.push_back({MOD_NODISP, reg3, RM_DISP32});
        put_disp32(disp);
        return sse3e_pkg::ST_OK;
      end
      sse3e_pkg::AM_ABS: begin
        enc_body.push_back({MOD_NODISP, reg3, RM_SIB});
        enc_body.push_back(sse3e_pkg::BYTE_SIB_ABS);
        put_disp32(disp);
        return sse3e_pkg::ST_OK;
      end
      sse3e_pkg::AM_INDEX: begin
        enc_rex[1] = enc_rex[1] | it.index_reg[3];
        enc_body.push_back({MOD_NODISP, reg3, RM_SIB});
        enc_body.push_back({ss, it.index_reg[2:0], RM_DISP32});
        put_disp32(disp);
        return sse3e_pkg::ST_OK;
      end
      sse3e_pkg::AM_BASE, sse3e_pkg::AM_BASE_INDEX: ;
      default: return sse3e_pkg::ST_ADDRESS;
    endcase
    if (!it.has_displacement && base3 != RM_DISP32) md = MOD_NODISP;
    else if (it.has_displacement && $signed(disp) >= -128 && $signed(disp) <= 127)
      md = MOD_DISP8;
    else md = MOD_DISP32;
    enc_rex[0] = enc_rex[0] | it.rm_or_base_reg[3];
    if (it.address_mode == sse3e_pkg::AM_BASE_INDEX || base3 == RM_SIB) begin
      ib = NO_INDEX;
      if (it.address_mode == sse3e_pkg::AM_BASE_INDEX) begin
        ib = it.index_reg[2:0];
        enc_rex[1] = enc_rex[1] | it.index_reg[3];
      end
      enc_body.push_back({md, reg3, RM_SIB});
      enc_body.push_back({ss, ib, base3});
    end else begin
      enc_body.push_back({md, reg3, base3});
    end
    if (md == MOD_DISP8) enc_body.push_back(disp[7:0]);
    else if (md == MOD_DISP32) put_disp32(disp);
    return sse3e_pkg::ST_OK;
  endfunction

  function automatic void predict_encoding(input sse3e_pkg::in_item_t it);
    logic [7:0]           code[$];
    logic [7:0]           pfx;
    logic [7:0]           opc;
    sse3e_pkg::status_t   st;
    sse3e_pkg::out_item_t r;
    logic [3:0]           op;
    op = it.operation;
    st = sse3e_pkg::ST_OK;
    enc_body = {};
    enc_rex = 3'b000;
    case (op)
      sse3e_pkg::OP_ADDSUBPD, sse3e_pkg::OP_HADDPD, sse3e_pkg::OP_HSUBPD: pfx = 8'h66;
      sse3e_pkg::OP_MOVSHDUP, sse3e_pkg::OP_MOVSLDUP:                     pfx = 8'hf3;
      default:                                                            pfx = 8'hf2;
    endcase
    case (op)
      sse3e_pkg::OP_ADDSUBPD, sse3e_pkg::OP_ADDSUBPS: opc = 8'hd0;
      sse3e_pkg::OP_HADDPD, sse3e_pkg::OP_HADDPS:     opc = 8'h7c;
      sse3e_pkg::OP_HSUBPD, sse3e_pkg::OP_HSUBPS:     opc = 8'h7d;
      sse3e_pkg::OP_LDDQU:                            opc = 8'hf0;
      sse3e_pkg::OP_MOVSHDUP:                         opc = 8'h16;
      default:                                        opc = 8'h12;
    endcase
    if (op <= sse3e_pkg::OP_MOVSLDUP) begin
      if (it.operand_count != 2'd2 || it.dst_kind != sse3e_pkg::KIND_REG) begin
        st = sse3e_pkg::ST_OPERAND;
      end else begin
        enc_rex[2] = it.modrm_reg_number[3];
        enc_body.push_back(sse3e_pkg::BYTE_ESC);
        enc_body.push_back(opc);
        st = encode_operand(it, it.src_kind, it.modrm_reg_number[2:0]);
        code.push_back(pfx);
      end
    end else if (op == sse3e_pkg::OP_FISTTP) begin
      if (it.operand_count != 2'd1 || it.dst_kind != sse3e_pkg::KIND_MEM ||
          it.store_width == sse3e_pkg::SW_BAD) begin
        st = sse3e_pkg::ST_OPERAND;
      end else begin
        case (it.store_width)
          sse3e_pkg::SW_16: enc_body.push_back(sse3e_pkg::BYTE_FIST16);
          sse3e_pkg::SW_32: enc_body.push_back(sse3e_pkg::BYTE_FIST32);
          default:          enc_body.push_back(sse3e_pkg::BYTE_FIST64);
        endcase
        st = encode_operand(it, sse3e_pkg::KIND_MEM, 3'd1);
      end
    end else if (op == sse3e_pkg::OP_MONITOR || op == sse3e_pkg::OP_MWAIT) begin
      if (it.operand_count != 2'd0) begin
        st = sse3e_pkg::ST_OPERAND;
      end else begin
        enc_body.push_back(sse3e_pkg::BYTE_ESC);
        enc_body.push_back(sse3e_pkg::BYTE_GRP7);
        enc_body.push_back(op == sse3e_pkg::OP_MONITOR ? sse3e_pkg::BYTE_MONITOR :
                                                         sse3e_pkg::BYTE_MWAIT);
      end
    end else begin
      st = sse3e_pkg::ST_OPERAND;
    end
    if (enc_rex != 3'b000) code.push_back(sse3e_pkg::BYTE_REX | {5'b0, enc_rex});
    foreach (enc_body[i]) code.push_back(enc_body[i]);
    if (st == sse3e_pkg::ST_OK && code.size() > model_capacity) st = sse3e_pkg::ST_CAPACITY;
    if (st != sse3e_pkg::ST_OK) begin
      r.out_byte = 8'h00;
      r.last_byte = 1'b1;
      r.status = st;
      r.instruction_length = 4'd0;
      pending_bytes.push_back(r);
    end else begin
      foreach (code[i]) begin
        r.out_byte = code[i];
        r.last_byte = (i == code.size() - 1);
        r.status = sse3e_pkg::ST_OK;
        r.instruction_length = 4'(code.size());
        pending_bytes.push_back(r);
      end
    end
  endfunction

  function automatic sse3e_pkg::in_item_t instr(input logic [3:0] op, input logic [1:0] cnt,
                                                input logic [1:0] dk, input logic [1:0] sk,
                                                input logic [3:0] rg, input logic [3:0] base,
                                                input logic [2:0] am, input logic [3:0] idx,
                                                input logic [3:0] sc, input logic hd,
                                                input logic [31:0] disp,
                                                input logic [1:0] sw);
    sse3e_pkg::in_item_t it;
    it.operation = op;
    it.operand_count = cnt;
    it.dst_kind = dk;
    it.src_kind = sk;
    it.modrm_reg_number = rg;
    it.rm_or_base_reg = base;
    it.address_mode = am;
    it.index_reg = idx;
    it.scale = sc;
    it.has_displacement = hd;
    it.displacement = disp;
    it.store_width = sw;
    return it;
  endfunction

  function automatic sse3e_pkg::in_item_t random_instr();
    sse3e_pkg::in_item_t it;
    int unsigned         pick;
    it = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick >= 85) return it;
    if (pick < 55) begin
      it.operation = 4'($urandom_range(0, 9));
      it.operand_count = 2'd2;
      it.dst_kind = sse3e_pkg::KIND_REG;
      it.src_kind = ($urandom_range(0, 3) == 0) ? sse3e_pkg::KIND_REG : sse3e_pkg::KIND_MEM;
    end else if (pick < 75) begin
      it.operation = sse3e_pkg::OP_FISTTP;
      it.operand_count = 2'd1;
      it.dst_kind = sse3e_pkg::KIND_MEM;
      it.store_width = ($urandom_range(0, 15) == 0) ? sse3e_pkg::SW_BAD :
                                                      2'($urandom_range(0, 2));
    end else begin
      it.operation = $urandom_range(0, 1) ? sse3e_pkg::OP_MONITOR : sse3e_pkg::OP_MWAIT;
      it.operand_count = 2'd0;
    end
    if ($urandom_range(0, 19) != 0) begin
      case ($urandom_range(0, 4))
        0:       it.scale = 4'd0;
        1:       it.scale = 4'd1;
        2:       it.scale = 4'd2;
        3:       it.scale = 4'd4;
        default: it.scale = 4'd8;
      endcase
    end
    if ($urandom_range(0, 19) != 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2: it.address_mode = sse3e_pkg::AM_BASE;
        3, 4, 5: it.address_mode = sse3e_pkg::AM_BASE_INDEX;
        6:       it.address_mode = sse3e_pkg::AM_INDEX;
        7:       it.address_mode = sse3e_pkg::AM_RIP;
        default: it.address_mode = sse3e_pkg::AM_ABS;
      endcase
    end
    case ($urandom_range(0, 7))
      0:       it.rm_or_base_reg[2:0] = RM_SIB;
      1:       it.rm_or_base_reg[2:0] = RM_DISP32;
      default: ;
    endcase
    case ($urandom_range(0, 7))
      0:       it.displacement = 32'h0000007f;
      1:       it.displacement = 32'h00000080;
      2:       it.displacement = 32'hffffff80;
      3:       it.displacement = 32'hffffff7f;
      4, 5:    it.displacement = 32'($urandom_range(0, 255)) - 32'd128;
      default: ;
    endcase
    return it;
  endfunction

  task automatic offer_instruction(input sse3e_pkg::in_item_t it);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic write_capacity(input logic [4:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    model_capacity = value;
  endtask

  task automatic run_random(input int unsigned count);
    sse3e_pkg::in_item_t it;
    for (int n = 0; n < count; n++) begin
      it = random_instr();
      offer_instruction(it);
      predict_encoding(it);
    end
    in_ch.valid <= 1'b0;
    burst_left = 0;
  endtask

  // receiver: free run, then random stalls, then a fixed stall pattern
  always @(posedge clk) begin
    stall_phase <= stall_phase + 8'd1;
    if (stall_phase < 8'd64) out_ch.ready <= 1'b1;
    else if (stall_phase < 8'd160) out_ch.ready <= ($urandom_range(0, 3) != 0);
    else out_ch.ready <= STALL_PATTERN[stall_phase[3:0]];
  end

  always @(posedge clk) begin
    sse3e_pkg::out_item_t want;
    sse3e_pkg::out_item_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_bytes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected item: byte %02h last %0d status %0d length %0d",
                   got.out_byte, got.last_byte, got.status, got.instruction_length);
      end else begin
        want = pending_bytes.pop_front();
        if (got.out_byte !== want.out_byte || got.last_byte !== want.last_byte ||
            got.status !== want.status ||
            got.instruction_length !== want.instruction_length) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected %02h/%0d/%0d/%0d, got %02h/%0d/%0d/%0d",
                     want.out_byte, want.last_byte, want.status, want.instruction_length,
                     got.out_byte, got.last_byte, got.status, got.instruction_length);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("sse3_instruction_encoder verification failed");
    $finish;
  end

  initial begin
    sse3e_pkg::out_item_t r;
    logic [4:0]           cap;
    int unsigned          drain;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;

    directed.push_back('{1'b1, sse3e_pkg::ST_OK, 4, 32'h660fd0c1,
      instr(sse3e_pkg::OP_ADDSUBPD, 2, sse3e_pkg::KIND_REG, sse3e_pkg::KIND_REG, 0, 1,
            sse3e_pkg::AM_BASE, 0, 0, 0, 0, sse3e_pkg::SW_16)});
    directed.push_back('{1'b0, sse3e_pkg::ST_OK, 0, 32'h0,
      instr(sse3e_pkg::OP_ADDSUBPS, 2, sse3e_pkg::KIND_REG, sse3e_pkg::KIND_REG, 15, 15,
            sse3e_pkg::AM_BASE, 15, 15, 1, 32'hffffffff, sse3e_pkg::SW_BAD)});
    directed.push_back('{1'b0, sse3e_pkg::ST_OK, 0, 32'h0,
      instr(sse3e_pkg::OP_HADDPD, 2, sse3e_pkg::KIND_REG, sse3e_pkg::KIND_MEM, 3, 0,
            sse3e_pkg::AM_BASE, 0, 0, 0, 0, sse3e_pkg::SW_16)});
    directed.push_back('{1'b0, sse3e_pkg::ST_OK, 0, 32'h0,
      instr(sse3e_pkg::OP_HADDPS, 2, sse3e_pkg::KIND_REG, sse3e_pkg::KIND_MEM, 9, 13,
            sse3e_pkg::AM_BASE, 0, 1, 0, 32'h12345678, sse3e_pkg::SW_16)});
    directed.push_back('{1'b0, sse3e_pkg::ST_OK, 0, 32'h0,
      instr(sse3e_pkg::OP_HSUBPD, 2, sse3e_pkg::KIND_REG, sse3e_pkg::KIND_MEM, 5, 4,
            sse3e_pkg::AM_BASE, 0, 2, 1, 32'hffffff80, sse3e_pkg::SW_16)});
    directed.push_back('{1'b0, sse3e_pkg::ST_OK, 0, 32'h0,
      instr(sse3e_pkg::OP_HSUBPS, 2, sse3e_pkg::KIND_REG, sse3e_pkg::KIND_MEM, 8, 12,
            sse3e_pkg::AM_BASE_INDEX, 15, 8, 1, 32'h80, sse3e_pkg::SW_16)});
    directed.push_back('{1'b0, sse3e_pkg::ST_OK, 0, 32'h0,
      instr(sse3e_pkg::OP_LDDQU, 2, sse3e_pkg::KIND_REG, sse3e_pkg::KIND_REG, 10, 3,
            sse3e_pkg::AM_BASE, 0, 0, 0, 0, sse3e_pkg::SW_16)});
    directed.push_back('{1'b0, sse3e_pkg::ST_OK, 0, 32'h0,
      instr(sse3e_pkg::OP_LDDQU, 2, sse3e_pkg::KIND_REG, sse3e_pkg::KIND_MEM, 1, 0,
            sse3e_pkg::AM_RIP, 0, 0, 1, 32'h80000000, sse3e_pkg::SW_16)});
    directed.push_back('{1'b0, sse3e_pkg::ST_OK, 0, 32'h0,
      instr(sse3e_pkg::OP_MOVDDUP, 2, sse3e_pkg::KIND_REG, sse3e_pkg::KIND_MEM, 14, 0,
            sse3e_pkg::AM_ABS, 0, 0, 1, 32'h7fffffff, sse3e_pkg::SW_16)});
    directed.push_back('{1'b0, sse3e_pkg::ST_OK, 0, 32'h0,
      instr(sse3e_pkg::OP_MOVSHDUP, 2, sse3e_pkg::KIND_REG, sse3e_pkg::KIND_MEM, 2, 0,
            sse3e_pkg::AM_INDEX, 9, 4, 1, 32'h7f, sse3e_pkg::SW_16)});
    directed.push_back('{1'b0, sse3e_pkg::ST_OK, 0, 32'h0,
      instr(sse3e_pkg::OP_MOVSLDUP, 2, sse3e_pkg::KIND_REG, sse3e_pkg::KIND_MEM, 6, 5,
            sse3e_pkg::AM_BASE_INDEX, 4, 1, 0, 32'hffffff7f, sse3e_pkg::SW_16)});
    directed.push_back('{1'b0, sse3e_pkg::ST_OK, 0, 32'h0,
      instr(sse3e_pkg::OP_FISTTP, 1, sse3e_pkg::KIND_MEM, sse3e_pkg::KIND_REG, 0, 0,
            sse3e_pkg::AM_BASE, 0, 0, 0, 0, sse3e_pkg::SW_16)});
    directed.push_back('{1'b0, sse3e_pkg::ST_OK, 0, 32'h0,
      instr(sse3e_pkg::OP_FISTTP, 1, sse3e_pkg::KIND_MEM, sse3e_pkg::KIND_REG, 0, 11,
            sse3e_pkg::AM_BASE_INDEX, 3, 2, 1, 5, sse3e_pkg::SW_32)});
    directed.push_back('{1'b0, sse3e_pkg::ST_OK, 0, 32'h0,
      instr(sse3e_pkg::OP_FISTTP, 1, sse3e_pkg::KIND_MEM, sse3e_pkg::KIND_REG, 0, 0,
            sse3e_pkg::AM_RIP, 0, 0, 0, 0, SW_64)});
    directed.push_back('{1'b1, sse3e_pkg::ST_OPERAND, 0, 32'h0,
      instr(sse3e_pkg::OP_FISTTP, 1, sse3e_pkg::KIND_MEM, sse3e_pkg::KIND_REG, 0, 0,
            sse3e_pkg::AM_BASE, 0, 0, 0, 0, sse3e_pkg::SW_BAD)});
    directed.push_back('{1'b1, sse3e_pkg::ST_OK, 3, 32'h0f01c800,
      instr(sse3e_pkg::OP_MONITOR, 0, sse3e_pkg::KIND_REG, sse3e_pkg::KIND_REG, 0, 0,
            sse3e_pkg::AM_BASE, 0, 0, 0, 0, sse3e_pkg::SW_16)});
    directed.push_back('{1'b1, sse3e_pkg::ST_OK, 3, 32'h0f01c900,
      instr(sse3e_pkg::OP_MWAIT, 0, sse3e_pkg::KIND_REG, sse3e_pkg::KIND_REG, 0, 0,
            sse3e_pkg::AM_BASE, 0, 0, 0, 0, sse3e_pkg::SW_16)});
    directed.push_back('{1'b1, sse3e_pkg::ST_OPERAND, 0, 32'h0,
      instr(OP_RSVD13, 2, sse3e_pkg::KIND_REG, sse3e_pkg::KIND_REG, 0, 0,
            sse3e_pkg::AM_BASE, 0, 0, 0, 0, sse3e_pkg::SW_16)});
    directed.push_back('{1'b1, sse3e_pkg::ST_OPERAND, 0, 32'h0,
      instr(OP_RSVD15, 0, sse3e_pkg::KIND_REG, sse3e_pkg::KIND_REG, 0, 0,
            sse3e_pkg::AM_BASE, 0, 0, 0, 0, sse3e_pkg::SW_16)});
    directed.push_back('{1'b1, sse3e_pkg::ST_OPERAND, 0, 32'h0,
      instr(sse3e_pkg::OP_HADDPD, 3, sse3e_pkg::KIND_REG, sse3e_pkg::KIND_REG, 0, 0,
            sse3e_pkg::AM_BASE, 0, 0, 0, 0, sse3e_pkg::SW_16)});
    directed.push_back('{1'b1, sse3e_pkg::ST_OPERAND, 0, 32'h0,
      instr(sse3e_pkg::OP_HSUBPS, 2, sse3e_pkg::KIND_MEM, sse3e_pkg::KIND_MEM, 0, 0,
            sse3e_pkg::AM_BASE, 0, 3, 0, 0, sse3e_pkg::SW_16)});
    directed.push_back('{1'b1, sse3e_pkg::ST_OPERAND, 0, 32'h0,
      instr(sse3e_pkg::OP_MOVDDUP, 2, sse3e_pkg::KIND_REG, KIND_OTHER, 0, 0,
            sse3e_pkg::AM_BASE, 0, 0, 0, 0, sse3e_pkg::SW_16)});
    directed.push_back('{1'b1, sse3e_pkg::ST_ADDRESS, 0, 32'h0,
      instr(sse3e_pkg::OP_ADDSUBPS, 2, sse3e_pkg::KIND_REG, sse3e_pkg::KIND_MEM, 0, 0,
            sse3e_pkg::AM_BASE, 0, 3, 0, 0, sse3e_pkg::SW_16)});
    directed.push_back('{1'b1, sse3e_pkg::ST_ADDRESS, 0, 32'h0,
      instr(sse3e_pkg::OP_FISTTP, 1, sse3e_pkg::KIND_MEM, sse3e_pkg::KIND_REG, 0, 0,
            AM_NONE, 0, 2, 1, 32'h10, sse3e_pkg::SW_32)});
    directed.push_back('{1'b1, sse3e_pkg::ST_OPERAND, 0, 32'h0,
      instr(sse3e_pkg::OP_MONITOR, 1, sse3e_pkg::KIND_REG, sse3e_pkg::KIND_REG, 0, 0,
            sse3e_pkg::AM_BASE, 0, 0, 0, 0, sse3e_pkg::SW_16)});

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[k]) begin
      offer_instruction(directed[k].item);
      if (!directed[k].typed) begin
        predict_encoding(directed[k].item);
      end else if (directed[k].status != sse3e_pkg::ST_OK) begin
        r.out_byte = 8'h00;
        r.last_byte = 1'b1;
        r.status = directed[k].status;
        r.instruction_length = 4'd0;
        pending_bytes.push_back(r);
      end else begin
        for (int i = 0; i < directed[k].nbytes; i++) begin
          r.out_byte = directed[k].bytes[31 - 8*i -: 8];
          r.last_byte = (i == directed[k].nbytes - 1);
          r.status = sse3e_pkg::ST_OK;
          r.instruction_length = 4'(directed[k].nbytes);
          pending_bytes.push_back(r);
        end
      end
    end
    run_random(14);

    for (int p = 0; p < 7; p++) begin
      cap = (p == 6) ? 5'($urandom_range(0, 31)) : capacity_plan[p];
      while (pending_bytes.size() != 0) @(posedge clk);
      write_capacity(cap);
      run_random(33);
    end

    drain = 0;
    while (pending_bytes.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);
    if (pending_bytes.size() != 0) begin
      $display("%0d expected items never arrived", pending_bytes.size());
      mismatch_count += pending_bytes.size();
    end
    if (mismatch_count == 0)
      $display("sse3_instruction_encoder verification clean");
    else
      $display("sse3_instruction_encoder verification failed");
    $finish;
  end

endmodule
